[sv/fsqd_pkg.sv]
package fsqd_pkg;

  localparam int NUM_ROWS  = 768;
  localparam int COEF_BITS = 16;
  localparam int NDIG      = 5;

  localparam int OP_W     = 2;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 3;
  localparam int IN_COEF_W = 16;
  localparam int IDX_W    = 14;
  localparam int OUT_W    = 21;
  localparam int NORM_W   = 4;
  localparam int DIG8_W   = 3;
  // three radix-8 digits sit in the low bits, the two radix-5 digits above
  localparam int LOW_W    = 3 * DIG8_W;
  localparam int TOP_W    = IDX_W - LOW_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [OP_W-1:0] OP_WRITE_WEIGHT = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_BIAS   = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE       = 2'd2;

  typedef logic signed [NORM_W-1:0]    norm_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef struct packed {
    logic [OP_W-1:0]        kind;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       column;
    coef_t                  coef;
    norm_t [NDIG-1:0]       norm;
  } cmd_t;

endpackage

[sv/fsqd_front.sv]
module fsqd_front
  import fsqd_pkg::*;
(
  input  logic [OP_W-1:0]             operation,
  input  logic [ROW_W-1:0]            row,
  input  logic [COL_W-1:0]            column,
  input  logic signed [IN_COEF_W-1:0] coef_value,
  input  logic [IDX_W-1:0]            token_index,
  output logic                        keep,
  output cmd_t                        cmd
);

  localparam int LEVEL_HI = 5;
  localparam int TAB_N    = 2 ** TOP_W;

  // upper two digits of the index: {(t/5) mod 5, t mod 5} for t = index >> 9
  function automatic logic [TAB_N*2*DIG8_W-1:0] make_tab();
    logic [TAB_N*2*DIG8_W-1:0] t;
    t = '0;
    for (int i = 0; i < TAB_N; i++) begin
      t[i*2*DIG8_W +: 2*DIG8_W] = {DIG8_W'((i / LEVEL_HI) % LEVEL_HI),
                                   DIG8_W'(i % LEVEL_HI)};
    end
    return t;
  endfunction

  localparam logic [TAB_N*2*DIG8_W-1:0] TOP_TAB = make_tab();

  logic [TOP_W-1:0]    top;
  logic [2*DIG8_W-1:0] top_digits;
  logic [DIG8_W-1:0]   d3, d4;
  logic                row_ok;

  assign top        = token_index[IDX_W-1:LOW_W];
  assign top_digits = TOP_TAB[top*2*DIG8_W +: 2*DIG8_W];
  assign d3         = top_digits[DIG8_W-1:0];
  assign d4         = top_digits[2*DIG8_W-1:DIG8_W];
  assign row_ok     = row < ROW_W'(NUM_ROWS);

  always_comb begin
    keep = 1'b0;
    case (operation)
      OP_WRITE_WEIGHT: keep = row_ok && (column < COL_W'(NDIG));
      OP_WRITE_BIAS:   keep = row_ok;
      OP_DECODE:       keep = row_ok;
      default:         keep = 1'b0;
    endcase
  end

  always_comb begin
    cmd.kind   = operation;
    cmd.row    = row;
    cmd.column = column;
    cmd.coef   = COEF_BITS'(coef_value);
    // level 8: digit - 4; level 5: 2 * (digit - 2); both carry 2 fraction bits
    cmd.norm[0] = {1'b0, token_index[DIG8_W-1:0]} - NORM_W'(4);
    cmd.norm[1] = {1'b0, token_index[2*DIG8_W-1:DIG8_W]} - NORM_W'(4);
    cmd.norm[2] = {1'b0, token_index[3*DIG8_W-1:2*DIG8_W]} - NORM_W'(4);
    cmd.norm[3] = {d3, 1'b0} - NORM_W'(4);
    cmd.norm[4] = {d4, 1'b0} - NORM_W'(4);
  end

endmodule

[sv/fsqd_queue.sv]
module fsqd_queue
  import fsqd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assign head_valid = count != '0;
  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_cmd   = slots[rd_ptr];

endmodule

[sv/fsqd_back.sv]
module fsqd_back
  import fsqd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    head_valid,
  input  cmd_t                    head_cmd,
  output logic                    pop,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic signed [OUT_W-1:0] embed_value,
  output logic [ROW_W-1:0]        row_echo
);

  logic adv;
  logic rd_en;

  // stage 1: store read
  logic                   s1_valid;
  logic [ROW_W-1:0]       s1_row;
  norm_t [NDIG-1:0]       s1_norm;
  logic [COEF_BITS-1:0]   rd_w [NDIG];
  logic [COEF_BITS-1:0]   rd_b;

  // stage 2: products
  logic                   s2_valid;
  logic [ROW_W-1:0]       s2_row;
  logic signed [OUT_W-1:0] s2_prod [NDIG];
  logic signed [OUT_W-1:0] s2_bias;

  logic signed [OUT_W-1:0] sum;

  logic [COEF_BITS-1:0]   weight_mem [NDIG][NUM_ROWS];
  logic [COEF_BITS-1:0]   bias_mem [NUM_ROWS];

  // whole pipe moves together; it only halts when the result register is held
  assign adv   = !res_valid || res_ready;
  assign pop   = head_valid && adv;
  assign rd_en = pop && (head_cmd.kind == OP_DECODE);

  // one bank per column, each written and read at one address a cycle
  always_ff @(posedge clk) begin
    for (int c = 0; c < NDIG; c++) begin
      if (pop && head_cmd.kind == OP_WRITE_WEIGHT && head_cmd.column == COL_W'(c)) begin
        weight_mem[c][head_cmd.row] <= head_cmd.coef;
      end
      if (rd_en) begin
        rd_w[c] <= weight_mem[c][head_cmd.row];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_cmd.kind == OP_WRITE_BIAS) begin
      bias_mem[head_cmd.row] <= head_cmd.coef;
    end
    if (rd_en) begin
      rd_b <= bias_mem[head_cmd.row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= rd_en;
      s2_valid  <= s1_valid;
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_row  <= head_cmd.row;
      s1_norm <= head_cmd.norm;
      s2_row  <= s1_row;
      for (int c = 0; c < NDIG; c++) begin
        s2_prod[c] <= OUT_W'($signed(s1_norm[c])) * OUT_W'($signed(rd_w[c]));
      end
      // bias is Q.12, products Q.14
      s2_bias     <= OUT_W'($signed(rd_b)) <<< 2;
      row_echo    <= s2_row;
      embed_value <= sum;
    end
  end

  always_comb begin
    sum = s2_bias;
    for (int c = 0; c < NDIG; c++) begin
      sum = sum + s2_prod[c];
    end
  end

endmodule

[sv/fsq_dequant_projection.sv]
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// command  | cmd_valid / cmd_ready  | operation, row, column, coef_value, token_index
// result   | res_valid / res_ready  | embed_value, row_echo
//
// One item per cycle sustained while results are taken; a decode result passes
// through the queue, the store read, the multiply and the result register (the
// sum feeds the result register directly).
// Writes and dropped items (bad row, bad column, unused operation) give no result.
// Reset clears the queue and pipeline valids; the weight and bias stores are
// not cleared. A held result stalls the back pipeline; commands are still
// taken until the 4-entry queue fills.
module fsq_dequant_projection
  import fsqd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  logic [OP_W-1:0]             operation,
  input  logic [ROW_W-1:0]            row,
  input  logic [COL_W-1:0]            column,
  input  logic signed [IN_COEF_W-1:0] coef_value,
  input  logic [IDX_W-1:0]            token_index,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic signed [OUT_W-1:0]     embed_value,
  output logic [ROW_W-1:0]            row_echo
);

  logic keep;
  cmd_t cmd;
  logic full;
  logic push;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  fsqd_front u_front (
    .operation   (operation),
    .row         (row),
    .column      (column),
    .coef_value  (coef_value),
    .token_index (token_index),
    .keep        (keep),
    .cmd         (cmd)
  );

  assign cmd_ready = !full;
  assign push      = cmd_valid && cmd_ready && keep;

  fsqd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  fsqd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .embed_value (embed_value),
    .row_echo    (row_echo)
  );

endmodule

[sv/fsqd_checker.sv]
module fsqd_checker
  import fsqd_pkg::*;
(
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic signed [OUT_W-1:0]     embed_value,
  input logic [ROW_W-1:0]            row_echo
);

  // held result keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(embed_value) && $stable(row_echo))
    else $error("result changed while stalled");

  // a result only leaves when taken
  a_res_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(res_valid) |-> $past(res_ready))
    else $error("result dropped without handshake");

  // out-of-range rows are filtered before the stores
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> row_echo < ROW_W'(NUM_ROWS))
    else $error("result row out of range");

  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid && cmd_ready)
    else $error("not empty after reset");

endmodule

bind fsq_dequant_projection fsqd_checker u_fsqd_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_ready   (cmd_ready),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .embed_value (embed_value),
  .row_echo    (row_echo)
);

[verif/fsq_dequant_projection_checker.sv]
module fsq_dequant_projection_checker
  import fsqd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  logic                        cmd_ready,
  input  logic [OP_W-1:0]             operation,
  input  logic [ROW_W-1:0]            row,
  input  logic [COL_W-1:0]            column,
  input  logic signed [IN_COEF_W-1:0] coef_value,
  input  logic [IDX_W-1:0]            token_index,
  input  logic                        res_valid,
  input  logic                        res_ready,
  input  logic signed [OUT_W-1:0]     embed_value,
  input  logic [ROW_W-1:0]            row_echo,
  output int                          fail_count,
  output int                          outstanding,
  output int                          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGIT_RADIX [NDIG] = '{8, 8, 8, 5, 5};
  localparam int DIGIT_PLACE [NDIG] = '{1, 8, 64, 512, 2560};

  typedef struct {
    logic signed [OUT_W-1:0] embed;
    logic [ROW_W-1:0]        row;
  } embed_item_t;

  coef_t       weight_tab [NUM_ROWS*NDIG];
  coef_t       bias_tab   [NUM_ROWS];
  embed_item_t pending_embeds [$];

  // bias plus the dot product of the normalised digits with the row weights
  function automatic logic signed [OUT_W-1:0] project_row(input int r, input int idx);
    int    acc;
    int    digit;
    norm_t norm;
    acc = int'(bias_tab[r]) * 4;
    for (int d = 0; d < NDIG; d++) begin
      digit = (idx / DIGIT_PLACE[d]) % DIGIT_RADIX[d];
      // two fraction bits: radix 8 gives digit-4, radix 5 gives (digit-2)*2
      if (DIGIT_RADIX[d] == 8)
        norm = norm_t'(digit - 4);
      else
        norm = norm_t'((digit - 2) * 2);
      acc += int'(norm) * int'(weight_tab[r*NDIG + d]);
    end
    return acc[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    embed_item_t want;
    embed_item_t got;
    int          errs;
    errs = 0;
    if (rst) begin
      pending_embeds.delete();
      fail_count      <= 0;
      results_checked <= 0;
    end else begin
      if (res_valid && res_ready) begin
        got.embed = embed_value;
        got.row   = row_echo;
        if (pending_embeds.size() == 0) begin
          $error("unexpected result: embed_value %0d row_echo %0d", got.embed, got.row);
          errs++;
        end else begin
          want = pending_embeds.pop_front();
          results_checked <= results_checked + 1;
          if (got.embed !== want.embed) begin
            $error("embed_value mismatch: expected %0d, got %0d (row %0d)",
                   want.embed, got.embed, want.row);
            errs++;
          end
          if (got.row !== want.row) begin
            $error("row_echo mismatch: expected %0d, got %0d", want.row, got.row);
            errs++;
          end
        end
      end
      if (cmd_valid && cmd_ready && row < NUM_ROWS) begin
        case (operation)
          OP_WRITE_WEIGHT: begin
            if (column < NDIG)
              weight_tab[row*NDIG + column] = coef_t'(coef_value);
          end
          OP_WRITE_BIAS: bias_tab[row] = coef_t'(coef_value);
          OP_DECODE: begin
            want.embed = project_row(int'(row), int'(token_index));
            want.row   = row;
            pending_embeds.push_back(want);
          end
          default: ;
        endcase
      end
      if (errs != 0)
        fail_count <= fail_count + errs;
    end
  end

  always @(posedge clk) outstanding <= pending_embeds.size();

endmodule

[verif/fsq_dequant_projection_tb.sv]
module fsq_dequant_projection_tb;
  import fsqd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1600;

  logic                        clk;
  logic                        rst;
  logic                        cmd_valid;
  logic                        cmd_ready;
  logic [OP_W-1:0]             operation;
  logic [ROW_W-1:0]            row;
  logic [COL_W-1:0]            column;
  logic signed [IN_COEF_W-1:0] coef_value;
  logic [IDX_W-1:0]            token_index;
  logic                        res_valid;
  logic                        res_ready;
  logic signed [OUT_W-1:0]     embed_value;
  logic [ROW_W-1:0]            row_echo;

  int fail_count;
  int outstanding;
  int results_checked;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_burst    = 0;

  // bit per weight column plus the bias bit; a row may be decoded once all are set
  logic [NDIG:0] row_written [NUM_ROWS];
  int            loaded_rows [$];
  int            ignored_items = 0;

  fsq_dequant_projection DUT (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .operation   (operation),
    .row         (row),
    .column      (column),
    .coef_value  (coef_value),
    .token_index (token_index),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .embed_value (embed_value),
    .row_echo    (row_echo)
  );

  fsq_dequant_projection_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .operation       (operation),
    .row             (row),
    .column          (column),
    .coef_value      (coef_value),
    .token_index     (token_index),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .embed_value     (embed_value),
    .row_echo        (row_echo),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("fsq_dequant_projection verification failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when stall_burst is loaded
  initial begin
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_burst > 0) begin
        res_ready <= 1'b0;
        stall_burst--;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic issue(input logic [OP_W-1:0] op, input int r, input int col,
                       input logic [IN_COEF_W-1:0] coef, input int idx);
    logic was_full;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid   <= 1'b1;
    operation   <= op;
    row         <= r[ROW_W-1:0];
    column      <= col[COL_W-1:0];
    coef_value  <= coef;
    token_index <= idx[IDX_W-1:0];
    do @(posedge clk); while (!cmd_ready);
    if (r < NUM_ROWS) begin
      was_full = &row_written[r];
      if (op == OP_WRITE_WEIGHT && col < NDIG)
        row_written[r][col] = 1'b1;
      else if (op == OP_WRITE_BIAS)
        row_written[r][NDIG] = 1'b1;
      if (!was_full && &row_written[r])
        loaded_rows.push_back(r);
    end
  endtask

  function automatic logic [IN_COEF_W-1:0] rand_coef();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return IN_COEF_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic load_row(input int r, input logic [IN_COEF_W-1:0] fill, input bit scramble);
    for (int c = 0; c < NDIG; c++)
      issue(OP_WRITE_WEIGHT, r, c, scramble ? rand_coef() : fill, $urandom_range(16383));
    issue(OP_WRITE_BIAS, r, $urandom_range(7), scramble ? rand_coef() : fill,
          $urandom_range(16383));
  endtask

  initial begin
    int  counted;
    int  pick;
    int  r;
    int  idx;
    int  phase;
    bit  held;
    rst         = 1'b1;
    cmd_valid   = 1'b0;
    operation   = OP_WRITE_WEIGHT;
    row         = '0;
    column      = '0;
    coef_value  = '0;
    token_index = '0;
    counted     = 0;
    held        = 1'b0;
    for (int i = 0; i < NUM_ROWS; i++)
      row_written[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme coefficients and digits, then the dropped cases
    load_row(0, 16'h8000, 1'b0);
    load_row(NUM_ROWS-1, 16'h7FFF, 1'b0);
    issue(OP_DECODE, 0, 0, 16'h0000, 0);
    issue(OP_DECODE, 0, 7, 16'hFFFF, 12799);
    issue(OP_DECODE, NUM_ROWS-1, 0, 16'h0000, 12799);
    issue(OP_DECODE, NUM_ROWS-1, 0, 16'h0000, 16383);  // top digit wraps
    issue(OP_DECODE, NUM_ROWS-1, 0, 16'h0000, 2600);
    issue(OP_WRITE_WEIGHT, 1023, 4, 16'h7FFF, 0);      // row beyond table
    issue(OP_WRITE_BIAS, NUM_ROWS, 0, 16'h7FFF, 0);
    issue(OP_WRITE_WEIGHT, 0, 7, 16'h1234, 0);         // column beyond five
    issue(OP_UNUSED, 0, 0, 16'h7FFF, 16383);
    issue(OP_DECODE, 1023, 0, 16'h0000, 0);            // no result expected
    issue(OP_DECODE, 0, 0, 16'h0000, 16383);

    while (counted < RANDOM_ITEMS) begin
      phase = counted * 4 / RANDOM_ITEMS;
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      // long receiver hold-off while the sender streams, to back up the queue
      if (!held && counted >= 100) begin
        held        = 1'b1;
        stall_burst = 80;
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        load_row($urandom_range(NUM_ROWS-1), '0, 1'b1);
        counted += NDIG + 1;
      end else if (pick < 20) begin
        r = $urandom_range(NUM_ROWS-1);
        if ($urandom_range(5) == 0)
          issue(OP_WRITE_BIAS, r, $urandom_range(7), rand_coef(), $urandom_range(16383));
        else
          issue(OP_WRITE_WEIGHT, r, $urandom_range(NDIG-1), rand_coef(),
                $urandom_range(16383));
        counted++;
      end else if (pick < 80) begin
        r   = loaded_rows[$urandom_range(loaded_rows.size()-1)];
        idx = ($urandom_range(4) == 0) ? $urandom_range(12800, 16383)
                                       : $urandom_range(12799);
        issue(OP_DECODE, r, $urandom_range(7), rand_coef(), idx);
        counted++;
      end else begin
        case ($urandom_range(3))
          0: issue($urandom_range(1) ? OP_WRITE_BIAS : OP_WRITE_WEIGHT,
                   $urandom_range(NUM_ROWS, 1023), $urandom_range(7), rand_coef(),
                   $urandom_range(16383));
          1: issue(OP_WRITE_WEIGHT, $urandom_range(NUM_ROWS-1), $urandom_range(NDIG, 7),
                   rand_coef(), $urandom_range(16383));
          2: issue(OP_UNUSED, $urandom_range(1023), $urandom_range(7), rand_coef(),
                   $urandom_range(16383));
          default: issue(OP_DECODE, $urandom_range(NUM_ROWS, 1023), $urandom_range(7),
                         rand_coef(), $urandom_range(16383));
        endcase
        ignored_items++;
      end
    end
    cmd_valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Run covered %0d random items plus directed extremes, %0d dropped items,",
             counted, ignored_items);
    $display("%0d rows fully loaded and %0d decode results checked across four idle mixes.",
             loaded_rows.size(), results_checked);
    if (fail_count == 0)
      $display("fsq_dequant_projection verification clean");
    else
      $display("fsq_dequant_projection verification failed");
    $finish;
  end

endmodule
